>>> hdl/htfd_pkg.sv
// Package for the humidity/temperature frame decoder.
// Holds the item struct types, scaling constants and the CRC-8 helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htfd_pkg;

   // CRC-8 over each 16-bit word: polynomial 0x31, seed 0xFF, MSB first.
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Scale factors in hundredths per full-scale raw word (divided by 65535).
   localparam logic [14:0] TEMP_SCALE = 15'd17500;
   localparam logic [14:0] HUM_SCALE  = 15'd10000;
   // Temperature zero point, -45.00 degrees, in hundredths.
   localparam logic [16:0] TEMP_BIAS  = 17'd4500;
   // Half of the divisor, added before dividing to round to nearest.
   localparam logic [31:0] HALF_DEN   = 32'd32767;
   // Reciprocal of 100 in 2^-19 units; exact for magnitudes below 43699.
   localparam logic [12:0] RECIP_100  = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_TEMP_OFFSET = 1'b0,
      CSR_HUM_OFFSET  = 1'b1
   } csr_index_type;

   // One input frame.
   typedef struct packed {
      logic [7:0] temp_msb;
      logic [7:0] temp_lsb;
      logic [7:0] temp_check;
      logic [7:0] hum_msb;
      logic [7:0] hum_lsb;
      logic [7:0] hum_check;
   } frame_in_type;

   // One decoded result.
   typedef struct packed {
      logic               status;
      logic signed [15:0] temp_hundredths;
      logic signed [7:0]  temp_whole;
      logic signed [7:0]  temp_frac;
      logic signed [15:0] hum_hundredths;
      logic signed [7:0]  hum_whole;
      logic signed [7:0]  hum_frac;
   } frame_out_type;

   // Whole and fraction parts of a hundredths value.
   typedef struct packed {
      logic signed [7:0] whole;
      logic signed [7:0] frac;
   } split_type;

   // Advance the CRC by one byte.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // CRC of a word, high byte first.
   function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
      return crc8_byte(crc8_byte(CRC_INIT, hi), lo);
   endfunction

endpackage

`default_nettype wire

>>> hdl/humidity_temp_frame_decode.sv
// An accepted request item moves through a four-register pipeline (input, product,
// hundredths, output) to its response item on rsp_valid; one item per cycle is taken
// while the output moves on, and the pipeline holds its contents while rsp_ready is low.
// Reset (synchronous, active high) empties the pipeline and clears both offsets.
// Depends on htfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module humidity_temp_frame_decode (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  htfd_pkg::frame_in_type       req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output htfd_pkg::frame_out_type      rsp_data,
   input  wire                          csr_write,
   input  htfd_pkg::csr_index_type      csr_index,
   input  wire  [14:0]                  csr_wdata
);
   import htfd_pkg::*;

   // Offset registers.
   logic signed [14:0] temp_offset_ff, temp_offset_in;
   logic signed [14:0] hum_offset_ff,  hum_offset_in;

   // Pipeline valids and load enables.
   logic a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in, d_valid_ff, d_valid_in;
   logic a_load, b_load, c_load, d_load;

   // Stage A: captured frame.
   frame_in_type a_frame_ff, a_frame_in;

   // Stage B: checksum result and scaled raw words.
   logic        b_bad_ff, b_bad_in;
   logic [30:0] b_tprod_ff, b_tprod_in;
   logic [30:0] b_hprod_ff, b_hprod_in;

   // Stage C: rounded hundredths with offsets.
   logic               c_bad_ff, c_bad_in;
   logic signed [15:0] c_temp_ff, c_temp_in;
   logic signed [15:0] c_hum_ff,  c_hum_in;

   // Stage D: output item.
   frame_out_type d_out_ff, d_out_in;

   // Stage C working values.
   logic [31:0]        t_num, t_sum, h_num, h_sum;
   logic [14:0]        t_q, h_q;
   logic signed [16:0] t_total, h_total;
   split_type          t_split, h_split;

   // Split a hundredths value into whole (truncated, saturated) and fraction.
   function automatic split_type split_value(input logic signed [15:0] h);
      logic        neg;
      logic [15:0] mag;
      logic [28:0] prod;
      logic [9:0]  q;
      logic [16:0] q100;
      logic [15:0] rem;
      split_type   res;
      neg  = h[15];
      mag  = neg ? 16'(-h) : 16'(h);
      prod = 29'(mag) * 29'(RECIP_100);
      q    = prod[28:RECIP_SHIFT];
      q100 = 17'({q, 6'b0}) + 17'({q, 5'b0}) + 17'({q, 2'b0});
      rem  = mag - q100[15:0];
      if (neg) begin
         res.whole = (q > 10'd128) ? -8'sd128 : 8'(-$signed({1'b0, q}));
         res.frac  = 8'(-$signed({1'b0, rem[6:0]}));
      end else begin
         res.whole = (q > 10'd127) ? 8'sd127 : 8'(q);
         res.frac  = 8'({1'b0, rem[6:0]});
      end
      return res;
   endfunction

   // Handshake: a stage loads when it is empty or its contents move on.
   always_comb begin
      d_load    = !d_valid_ff || rsp_ready;
      c_load    = !c_valid_ff || d_load;
      b_load    = !b_valid_ff || c_load;
      a_load    = !a_valid_ff || b_load;
      req_ready = a_load;
      rsp_valid = d_valid_ff;
      rsp_data  = d_out_ff;
   end

   // Configuration writes.
   always_comb begin
      temp_offset_in = temp_offset_ff;
      hum_offset_in  = hum_offset_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TEMP_OFFSET: temp_offset_in = $signed(csr_wdata);
            CSR_HUM_OFFSET:  hum_offset_in  = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Valid bits follow the load enables.
   always_comb begin
      a_valid_in = a_load ? req_valid  : a_valid_ff;
      b_valid_in = b_load ? a_valid_ff : b_valid_ff;
      c_valid_in = c_load ? b_valid_ff : c_valid_ff;
      d_valid_in = d_load ? c_valid_ff : d_valid_ff;
   end

   // Stage A input capture.
   always_comb begin
      a_frame_in = a_load ? req_data : a_frame_ff;
   end

   // Stage B: checksums and one constant multiply per word.
   always_comb begin
      b_bad_in   = b_bad_ff;
      b_tprod_in = b_tprod_ff;
      b_hprod_in = b_hprod_ff;
      if (b_load) begin
         b_bad_in = (crc8_word(a_frame_ff.temp_msb, a_frame_ff.temp_lsb)
                     != a_frame_ff.temp_check) ||
                    (crc8_word(a_frame_ff.hum_msb, a_frame_ff.hum_lsb)
                     != a_frame_ff.hum_check);
         b_tprod_in = 31'({a_frame_ff.temp_msb, a_frame_ff.temp_lsb}) * 31'(TEMP_SCALE);
         b_hprod_in = 31'({a_frame_ff.hum_msb, a_frame_ff.hum_lsb}) * 31'(HUM_SCALE);
      end
   end

   // Stage C: round-to-nearest divide by 65535, then add the offsets.
   // For n below 2^32 with quotient under 2^16, n / 65535 equals
   // (n + 1 + (n >> 16)) >> 16. No ties occur since 65535 is odd, so the
   // integer offset can be added after rounding.
   always_comb begin
      t_num   = 32'(b_tprod_ff) + HALF_DEN;
      t_sum   = t_num + 32'd1 + (t_num >> 16);
      t_q     = t_sum[30:16];
      h_num   = 32'(b_hprod_ff) + HALF_DEN;
      h_sum   = h_num + 32'd1 + (h_num >> 16);
      h_q     = h_sum[30:16];
      t_total = {{2{temp_offset_ff[14]}}, temp_offset_ff} + $signed({2'b00, t_q})
                - $signed(TEMP_BIAS);
      h_total = {{2{hum_offset_ff[14]}}, hum_offset_ff} + $signed({2'b00, h_q});
      c_bad_in  = c_load ? b_bad_ff       : c_bad_ff;
      c_temp_in = c_load ? t_total[15:0]  : c_temp_ff;
      c_hum_in  = c_load ? h_total[15:0]  : c_hum_ff;
   end

   // Stage D: split into whole and fraction; a checksum error zeroes the values.
   always_comb begin
      t_split  = split_value(c_temp_ff);
      h_split  = split_value(c_hum_ff);
      d_out_in = d_out_ff;
      if (d_load) begin
         if (c_bad_ff) begin
            d_out_in        = '0;
            d_out_in.status = 1'b1;
         end else begin
            d_out_in.status          = 1'b0;
            d_out_in.temp_hundredths = c_temp_ff;
            d_out_in.temp_whole      = t_split.whole;
            d_out_in.temp_frac       = t_split.frac;
            d_out_in.hum_hundredths  = c_hum_ff;
            d_out_in.hum_whole       = h_split.whole;
            d_out_in.hum_frac        = h_split.frac;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         d_valid_ff     <= 1'b0;
         temp_offset_ff <= '0;
         hum_offset_ff  <= '0;
      end else begin
         a_valid_ff     <= a_valid_in;
         b_valid_ff     <= b_valid_in;
         c_valid_ff     <= c_valid_in;
         d_valid_ff     <= d_valid_in;
         temp_offset_ff <= temp_offset_in;
         hum_offset_ff  <= hum_offset_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      a_frame_ff <= a_frame_in;
      b_bad_ff   <= b_bad_in;
      b_tprod_ff <= b_tprod_in;
      b_hprod_ff <= b_hprod_in;
      c_bad_ff   <= c_bad_in;
      c_temp_ff  <= c_temp_in;
      c_hum_ff   <= c_hum_in;
      d_out_ff   <= d_out_in;
   end

endmodule

`default_nettype wire

>>> tb/humidity_temp_frame_decode_test.sv
// Self-checking testbench for the humidity/temperature frame decoder.
// Predicts each decoded reading in fixed-point hundredths and checks it field by field.
// Depends on htfd_pkg and humidity_temp_frame_decode.
`timescale 1ns / 1ps

module humidity_temp_frame_decode_test;

   import htfd_pkg::frame_in_type;
   import htfd_pkg::frame_out_type;
   import htfd_pkg::csr_index_type;
   import htfd_pkg::CSR_TEMP_OFFSET;
   import htfd_pkg::CSR_HUM_OFFSET;

   // Sensor checksum and scaling constants, in hundredths.
   localparam logic [7:0] CHECK_POLY = 8'h31;
   localparam logic [7:0] CHECK_SEED = 8'hFF;
   localparam longint RAW_SPAN = 65535;
   localparam longint RAW_HALF = 32767;
   localparam longint TEMP_SPAN = 17500;
   localparam longint TEMP_ZERO = 4500;
   localparam longint HUM_SPAN = 10000;
   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 135;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   frame_in_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   frame_out_type rsp_data;
   logic csr_write = 1'b0;
   csr_index_type csr_index = CSR_TEMP_OFFSET;
   logic [14:0] csr_wdata = '0;

   // Shadow copies of the offset registers.
   logic signed [14:0] temp_offset_set = '0;
   logic signed [14:0] hum_offset_set = '0;

   frame_in_type pending_frames[$];
   frame_out_type due_readings[$];
   int unsigned send_gap = 0;
   int unsigned recv_stall = 0;
   int unsigned max_gap = 0;
   logic hold_off_req = 1'b0;
   logic hold_done = 1'b0;
   int fail_count = 0;
   int quiet_cycles = 0;

   humidity_temp_frame_decode i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // CRC-8 of one word, processed bit by bit from the MSB.
   function automatic logic [7:0] word_check(input logic [15:0] w);
      logic [7:0] c;
      c = CHECK_SEED;
      for (int i = 15; i >= 0; i--) begin
         if (c[7] ^ w[i]) begin
            c = {c[6:0], 1'b0} ^ CHECK_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Divide by the raw full scale, rounding half away from zero.
   function automatic longint to_hundredths(input longint num);
      if (num >= 0) begin
         return (num + RAW_HALF) / RAW_SPAN;
      end
      return -((-num + RAW_HALF) / RAW_SPAN);
   endfunction

   // Split hundredths into a saturated whole part and a signed remainder.
   function automatic void split_reading(input longint h, output logic signed [15:0] hund,
                                         output logic signed [7:0] whole,
                                         output logic signed [7:0] frac);
      longint w;
      longint f;
      w = h / 100;
      f = h % 100;
      if (w > 127) begin
         w = 127;
      end
      if (w < -128) begin
         w = -128;
      end
      hund = h[15:0];
      whole = w[7:0];
      frac = f[7:0];
   endfunction

   // Expected reading for one frame under the current offsets.
   function automatic frame_out_type decode_frame(input frame_in_type f);
      frame_out_type r;
      longint traw;
      longint hraw;
      longint th;
      longint hh;
      r = '0;
      if (word_check({f.temp_msb, f.temp_lsb}) != f.temp_check ||
          word_check({f.hum_msb, f.hum_lsb}) != f.hum_check) begin
         r.status = 1'b1;
         return r;
      end
      traw = longint'({f.temp_msb, f.temp_lsb});
      hraw = longint'({f.hum_msb, f.hum_lsb});
      th = to_hundredths(TEMP_SPAN * traw + (longint'(temp_offset_set) - TEMP_ZERO) * RAW_SPAN);
      hh = to_hundredths(HUM_SPAN * hraw + longint'(hum_offset_set) * RAW_SPAN);
      split_reading(th, r.temp_hundredths, r.temp_whole, r.temp_frac);
      split_reading(hh, r.hum_hundredths, r.hum_whole, r.hum_frac);
      return r;
   endfunction

   // Well-formed frame with both checksums correct.
   function automatic frame_in_type make_frame(input logic [15:0] traw, input logic [15:0] hraw);
      frame_in_type f;
      f.temp_msb = traw[15:8];
      f.temp_lsb = traw[7:0];
      f.temp_check = word_check(traw);
      f.hum_msb = hraw[15:8];
      f.hum_lsb = hraw[7:0];
      f.hum_check = word_check(hraw);
      return f;
   endfunction

   // Mostly well-formed frames; the rest carry corrupted checksums or random bytes.
   function automatic frame_in_type random_frame();
      frame_in_type f;
      logic [15:0] traw;
      logic [15:0] hraw;
      int unsigned kind;
      kind = $urandom_range(0, 19);
      traw = 16'($urandom);
      hraw = 16'($urandom);
      if (kind == 0) begin
         traw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end else if (kind == 1) begin
         hraw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      f = make_frame(traw, hraw);
      case (kind)
         16: begin
            f.temp_check ^= 8'(1 << $urandom_range(0, 7));
         end
         17: begin
            f.hum_check ^= 8'(1 << $urandom_range(0, 7));
         end
         18: begin
            f = 48'({$urandom, $urandom});
         end
         19: begin
            f.temp_check ^= 8'($urandom_range(1, 255));
            f.hum_check ^= 8'($urandom_range(1, 255));
         end
         default: begin
         end
      endcase
      return f;
   endfunction

   // Write one offset register; only called while the decoder is idle.
   task automatic write_offset(input csr_index_type idx, input logic signed [14:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_TEMP_OFFSET) begin
         temp_offset_set = val;
      end else begin
         hum_offset_set = val;
      end
   endtask

   // Wait until every queued frame is sent and every reading has come back.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_frames.size() != 0 || req_valid || due_readings.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Queue the four corner frames of the raw words.
   task automatic queue_corners();
      pending_frames.push_back(make_frame(16'h0000, 16'h0000));
      pending_frames.push_back(make_frame(16'hFFFF, 16'hFFFF));
      pending_frames.push_back(make_frame(16'h0000, 16'hFFFF));
      pending_frames.push_back(make_frame(16'hFFFF, 16'h0000));
   endtask

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_reading(input frame_out_type got);
      frame_out_type want;
      if (due_readings.size() == 0) begin
         $error("reading arrived with none outstanding");
         fail_count++;
         return;
      end
      want = due_readings.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("temp_hundredths", $signed(want.temp_hundredths),
                    $signed(got.temp_hundredths));
      compare_field("temp_whole", $signed(want.temp_whole), $signed(got.temp_whole));
      compare_field("temp_frac", $signed(want.temp_frac), $signed(got.temp_frac));
      compare_field("hum_hundredths", $signed(want.hum_hundredths),
                    $signed(got.hum_hundredths));
      compare_field("hum_whole", $signed(want.hum_whole), $signed(got.hum_whole));
      compare_field("hum_frac", $signed(want.hum_frac), $signed(got.hum_frac));
   endtask

   // Sender: offers queued frames, predicting each reading as its frame is accepted.
   always @(posedge clock) begin : sender
      int unsigned gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (req_valid && req_ready) begin
         due_readings.push_back(decode_frame(req_data));
         gap = $urandom_range(0, max_gap);
         if (gap == 0 && pending_frames.size() != 0) begin
            req_data <= pending_frames.pop_front();
         end else begin
            req_valid <= 1'b0;
            send_gap <= gap;
         end
      end else if (!req_valid) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
         end else if (pending_frames.size() != 0) begin
            req_data <= pending_frames.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Receiver: checks each accepted reading and stalls at random between items.
   always @(posedge clock) begin : receiver
      int unsigned stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_reading(rsp_data);
         end
         if (hold_off_req && !hold_done) begin
            // One long hold-off so the pipeline fills and back-pressures the sender.
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
            recv_stall <= LONG_HOLD;
         end else if (rsp_valid && rsp_ready) begin
            stall = $urandom_range(0, max_gap);
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               recv_stall <= stall;
            end
         end else if (!rsp_ready) begin
            if (recv_stall <= 1) begin
               rsp_ready <= 1'b1;
            end else begin
               recv_stall <= recv_stall - 1;
            end
         end
      end
   end

   // Watchdog: ends the run if no item moves on either side for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("humidity_temp_frame_decode verification failed");
         $finish;
      end
   end

   // Stimulus: directed frames, then random phases under changing offsets.
   initial begin
      frame_in_type f;
      int t_off;
      int h_off;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset offsets.
      max_gap = 2;
      queue_corners();
      pending_frames.push_back(make_frame(16'h3A00, 16'h8000));
      pending_frames.push_back(make_frame(16'h6666, 16'h0001));
      f = make_frame(16'h6000, 16'h7000);
      f.temp_check ^= 8'h80;
      pending_frames.push_back(f);
      f = make_frame(16'h1234, 16'hABCD);
      f.hum_check ^= 8'h01;
      pending_frames.push_back(f);
      f = make_frame(16'h8000, 16'h4000);
      f.temp_check ^= 8'h0F;
      f.hum_check ^= 8'hF0;
      pending_frames.push_back(f);
      pending_frames.push_back('0);
      pending_frames.push_back('1);
      wait_drained();

      // Corner frames at the extreme offsets, stated range and full register range.
      write_offset(CSR_TEMP_OFFSET, 15'sd12700);
      write_offset(CSR_HUM_OFFSET, 15'sd10000);
      queue_corners();
      wait_drained();
      write_offset(CSR_TEMP_OFFSET, -15'sd12800);
      write_offset(CSR_HUM_OFFSET, -15'sd10000);
      queue_corners();
      wait_drained();
      write_offset(CSR_TEMP_OFFSET, -15'sd16384);
      write_offset(CSR_HUM_OFFSET, 15'sd16383);
      queue_corners();
      wait_drained();
      write_offset(CSR_TEMP_OFFSET, 15'sd16383);
      write_offset(CSR_HUM_OFFSET, -15'sd16384);
      queue_corners();
      wait_drained();

      // Random phases; gap range cycles through wide, none and short.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if ($urandom_range(0, 3) != 0) begin
            t_off = int'($urandom_range(0, 25500)) - 12800;
            h_off = int'($urandom_range(0, 20000)) - 10000;
         end else begin
            t_off = int'($urandom);
            h_off = int'($urandom);
         end
         write_offset(CSR_TEMP_OFFSET, 15'(t_off));
         write_offset(CSR_HUM_OFFSET, 15'(h_off));
         case (p % 3)
            0: max_gap = 17;
            1: max_gap = 0;
            default: max_gap = 3;
         endcase
         if (p == 2) begin
            hold_off_req = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pending_frames.push_back(random_frame());
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("humidity_temp_frame_decode verification clean");
      end else begin
         $display("humidity_temp_frame_decode verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/htfd_pkg.sv
hdl/humidity_temp_frame_decode.sv
tb/humidity_temp_frame_decode_test.sv
